### rtl/pwcl_pkg.sv
`timescale 1ns / 1ps

package pwcl_pkg;

	localparam int GAP_W  = 16;
	localparam int MIN_W  = 9;
	localparam int LONG_W = 16;
	localparam int TICK_W = 16;
	localparam int IDX_W  = 8;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_GAP_TICKS  = 2'd0;
	localparam logic [1:0] REG_MIN_BITS   = 2'd1;
	localparam logic [1:0] REG_LONG_TICKS = 2'd2;

	localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd100;
	localparam logic [MIN_W-1:0]  MIN_RESET  = 9'd24;
	localparam logic [LONG_W-1:0] LONG_RESET = 16'd8;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// Reported phase codes.
	localparam logic [1:0] PHASE_WAIT  = 2'd0;
	localparam logic [1:0] PHASE_READY = 2'd1;
	localparam logic [1:0] PHASE_LOG   = 2'd2;
	localparam logic [1:0] PHASE_DONE  = 2'd3;

	typedef enum logic [3:0] {
		ST_WAIT  = 4'b0001,
		ST_READY = 4'b0010,
		ST_LOG   = 4'b0100,
		ST_DONE  = 4'b1000
	} learn_state_t;

	typedef struct packed {
		logic [GAP_W-1:0]  gap_ticks;
		logic [MIN_W-1:0]  min_bits;
		logic [LONG_W-1:0] long_pulse_ticks;
	} cfg_t;

	// Packed from the top bit down; the lowest field sits at the bottom.
	typedef struct packed {
		logic [1:0]       phase;
		logic             overflow;
		logic             frame_done;
		logic             frame_discarded;
		logic [IDX_W-1:0] bit_index;
		logic             bit_value;
		logic             bit_valid;
	} result_t;

	localparam int RES_W = $bits(result_t);

	function automatic logic [1:0] phase_code(learn_state_t st);
		logic [1:0] code;
		unique case (st)
			ST_WAIT:  code = PHASE_WAIT;
			ST_READY: code = PHASE_READY;
			ST_LOG:   code = PHASE_LOG;
			ST_DONE:  code = PHASE_DONE;
			default:  code = PHASE_WAIT;
		endcase
		return code;
	endfunction

	function automatic logic [TICK_W-1:0] inc_sat(logic [TICK_W-1:0] v);
		return (v == TICK_MAX) ? v : v + 1'b1;
	endfunction

endpackage

### rtl/pwcl_regs.sv
`timescale 1ns / 1ps

module pwcl_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pwcl_pkg::APB_AW-1:0]    paddr,
	input  logic [pwcl_pkg::APB_DW-1:0]    pwdata,
	output logic [pwcl_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	output pwcl_pkg::cfg_t                 cfg
);
	import pwcl_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks        <= GAP_RESET;
			cfg_q.min_bits         <= MIN_RESET;
			cfg_q.long_pulse_ticks <= LONG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GAP_TICKS:  cfg_q.gap_ticks        <= pwdata[GAP_W-1:0];
				REG_MIN_BITS:   cfg_q.min_bits         <= pwdata[MIN_W-1:0];
				REG_LONG_TICKS: cfg_q.long_pulse_ticks <= pwdata[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GAP_TICKS:  prdata = APB_DW'(cfg_q.gap_ticks);
			REG_MIN_BITS:   prdata = APB_DW'(cfg_q.min_bits);
			REG_LONG_TICKS: prdata = APB_DW'(cfg_q.long_pulse_ticks);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/pwcl_core.sv
`timescale 1ns / 1ps

module pwcl_core #(
	parameter int MAX_BITS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pwcl_pkg::cfg_t    cfg,
	input  logic              step,
	input  logic              pin_level,
	input  logic              restart,
	output pwcl_pkg::result_t res
);
	import pwcl_pkg::*;

	localparam int CNT_W = $clog2(MAX_BITS + 1);
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	learn_state_t      state_q, state_d;
	logic [TICK_W-1:0] low_q, low_d, high_q, high_d;
	logic [CNT_W-1:0]  count_q, count_d;

	logic [TICK_W-1:0] low_inc, high_inc;
	logic [CNT_W-1:0]  count_mid;
	logic              gap_hit;

	assign low_inc    = inc_sat(low_q);
	assign high_inc   = inc_sat(high_q);
	assign gap_hit    = low_inc > cfg.gap_ticks;

	always_comb begin
		state_d   = state_q;
		low_d     = low_q;
		high_d    = high_q;
		count_d   = count_q;
		count_mid = count_q;
		res       = '0;

		if (restart) begin
			state_d = ST_WAIT;
			low_d   = '0;
			high_d  = '0;
			count_d = '0;
		end else begin
			unique case (state_q)
				ST_WAIT: begin
					if (pin_level) begin
						low_d = '0;
					end else begin
						low_d = low_inc;
						if (gap_hit) state_d = ST_READY;
					end
				end
				ST_READY: begin
					if (pin_level) begin
						state_d = ST_LOG;
						low_d   = '0;
						high_d  = high_inc;
					end
				end
				ST_LOG: begin
					if (pin_level) begin
						high_d = high_inc;
					end else begin
						low_d = low_inc;
						// Frame end is judged on the count before any bit of this tick.
						if (gap_hit) begin
							if (CMP_W'(count_q) < CMP_W'(cfg.min_bits)) begin
								count_mid           = '0;
								low_d               = '0;
								state_d             = ST_READY;
								res.frame_discarded = 1'b1;
							end else begin
								state_d = ST_DONE;
							end
						end
						count_d = count_mid;
						if (high_q != '0) begin
							if (count_mid < CNT_W'(MAX_BITS)) begin
								res.bit_valid = 1'b1;
								res.bit_value = high_q > cfg.long_pulse_ticks;
								res.bit_index = IDX_W'(CMP_W'(count_mid));
								count_d       = count_mid + 1'b1;
							end else begin
								res.overflow = 1'b1;
							end
							high_d = '0;
							low_d  = '0;
						end
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end

		res.frame_done = (state_d == ST_DONE);
		res.phase      = phase_code(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
			low_q   <= '0;
			high_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			low_q   <= low_d;
			high_q  <= high_d;
			count_q <= count_d;
		end
	end

endmodule

### rtl/pwcl_skid.sv
`timescale 1ns / 1ps

module pwcl_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pwcl_pkg::result_t push_word,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output pwcl_pkg::result_t out_word
);
	import pwcl_pkg::*;

	result_t main_q, skid_q;
	logic    main_valid_q, skid_valid_q;
	logic    pop;

	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;
	assign pop       = main_valid_q && out_ready;

	// A push only arrives while the skid slot is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (push && (pop || !main_valid_q)) begin
				main_valid_q <= 1'b1;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end else if (pop) begin
				main_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && (pop || !main_valid_q)) begin
			main_q <= push_word;
		end else if (push) begin
			skid_q <= push_word;
		end else if (pop) begin
			main_q <= skid_q;
		end
	end

endmodule

### rtl/pulse_width_code_learner.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Contents
// s_axis    in         s_axis_tvalid/tready       one pin sample word per tick
// m_axis    out        m_axis_tvalid/tready       one decode result word per sample
// apb       in         psel/penable, pready=1     three config registers at 0x0/0x4/0x8
//
// Each sample is decoded in the cycle it is accepted; its result is registered in the
// output buffer and shows on m_axis from there, so one word per cycle flows with no stalls.
// A two-entry output buffer lets input continue for one word after m_axis stalls;
// s_axis_tready falls only when both entries are full.
// arst_n clears the phase, tick counters and bit count; registers return to defaults.
module pulse_width_code_learner #(
	parameter int MAX_BITS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] pin_level, [1] restart, [7:2] zero
	input  logic [7:0]                  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [0] bit_valid, [1] bit_value, [9:2] bit_index, [10] frame_discarded,
	// [11] frame_done, [12] overflow, [14:13] phase, [15] zero
	output logic [15:0]                 m_axis_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwcl_pkg::APB_AW-1:0] paddr,
	input  logic [pwcl_pkg::APB_DW-1:0] pwdata,
	output logic [pwcl_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import pwcl_pkg::*;

	cfg_t    cfg;
	result_t res, out_word;
	logic    step, space;

	assign s_axis_tready = space;
	assign step          = s_axis_tvalid && space;

	pwcl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwcl_core #(
		.MAX_BITS (MAX_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.pin_level (s_axis_tdata[0]),
		.restart   (s_axis_tdata[1]),
		.res       (res)
	);

	pwcl_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_word (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word)
	);

	assign m_axis_tdata = {{(16 - RES_W){1'b0}}, out_word};

endmodule

### rtl/pwcl_checker.sv
`timescale 1ns / 1ps

module pwcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// The output stage only fills up when a word is waiting downstream.
	a_ready_low_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output word pending");

	a_done_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[11] == (m_axis_tdata[14:13] == 2'd3)))
		else $error("frame_done disagrees with phase");

	a_idle_bit_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[9:1] == 9'd0))
		else $error("bit value or index set without a bit");

	a_bit_excludes_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[12]))
		else $error("bit emitted and dropped on the same word");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output word changed");

endmodule

bind pulse_width_code_learner pwcl_checker u_pwcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
